// ===== rtl/core/quaternion_slerp_unit_assert.svh =====
// Assertion macros used by the quaternion slerp RTL.
// Users must have clk and rst in scope; no other dependencies.
`ifndef QUATERNION_SLERP_UNIT_ASSERT_SVH
`define QUATERNION_SLERP_UNIT_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define QSU_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked against the following cycle.
`define QSU_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/qslp_pkg.sv =====
// Package for the quaternion slerp unit: types, fixed-point constants, latencies.
// No dependencies.
`default_nettype none

package qslp_pkg;

  localparam int HSTEPS = 5;
  localparam int SIN_LAT = 3 * HSTEPS + 2;
  localparam int NSTEP = 31;
  localparam int QBITS = 32;
  localparam int CELL_LAT = SIN_LAT + 2;
  localparam int FRONT_LAT = 4;
  localparam int ACOS_END = FRONT_LAT + NSTEP * CELL_LAT;
  localparam int ANG_END = ACOS_END + SIN_LAT + 2;
  localparam int DIV_END = ANG_END + QBITS;
  localparam int TOTAL_LAT = DIV_END + 2;

  localparam logic [30:0] HALF_PI = 31'd1686629713;
  localparam logic [30:0] FX_ONE = 31'h4000_0000;

  // Horner divisors and their reciprocals scaled by 2^34.
  localparam logic [6:0] HDIV [HSTEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [31:0] HREC [HSTEPS] = '{
    32'd156180628, 32'd238609294, 32'd409044504, 32'd858993459, 32'd2863311530
  };

  typedef struct packed {
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] a_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] b_w;
    logic [16:0] blend_t;
  } qs_in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic signed [15:0] out_w;
  } qs_out_t;

  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][16:0] bn;
    logic [16:0] t;
    logic lin;
  } qs_mix_t;

  typedef struct packed {
    qs_mix_t mix;
    logic [32:0] dot;
    logic [30:0] lo;
    logic [30:0] hi;
    logic [30:0] mid;
  } qs_item_t;

  typedef struct packed {
    qs_mix_t mix;
    logic [30:0] den;
    logic [30:0] rem0;
    logic [30:0] rem1;
    logic [31:0] num0;
    logic [31:0] num1;
    logic [31:0] quo0;
    logic [31:0] quo1;
  } qs_div_t;

endpackage

`default_nettype wire

// ===== rtl/core/qslp_sine.sv =====
// Pipelined fixed-point sine, Taylor series in Horner form on Q30 angles.
// Depends on qslp_pkg.
`default_nettype none

module qslp_sine (
  input logic clk,
  input logic [30:0] x,
  output logic [30:0] y
);
  import qslp_pkg::*;

  logic [30:0] cx [HSTEPS+1];
  logic [31:0] cx2 [HSTEPS+1];
  logic [30:0] cterm [HSTEPS+1];
  logic [61:0] sq;
  logic [61:0] fin;

  assign sq = x * x;
  assign fin = cx[HSTEPS] * cterm[HSTEPS];

  always_ff @(posedge clk) begin
    cx[0] <= x;
    cx2[0] <= sq[61:30];
    cterm[0] <= FX_ONE;
    y <= fin[60:30];
  end

  for (genvar i = 0; i < HSTEPS; i++) begin : g_step
    logic [30:0] ax;
    logic [31:0] ax2;
    logic [31:0] ap;
    logic [30:0] bx;
    logic [31:0] bx2;
    logic [31:0] bp;
    logic [31:0] bq;
    logic [62:0] prod;
    logic [63:0] rprod;
    logic [38:0] qn;
    logic [31:0] rem;
    logic [31:0] q;

    assign prod = cx2[i] * cterm[i];
    assign rprod = ap * HREC[i];
    assign qn = bq * HDIV[i];
    assign rem = bp - qn[31:0];
    assign q = (rem >= {25'b0, HDIV[i]}) ? bq + 32'd1 : bq;

    always_ff @(posedge clk) begin
      ax <= cx[i];
      ax2 <= cx2[i];
      ap <= prod[61:30];
      bx <= ax;
      bx2 <= ax2;
      bp <= ap;
      bq <= {2'b0, rprod[63:34]};
      cx[i+1] <= bx;
      cx2[i+1] <= bx2;
      cterm[i+1] <= FX_ONE - q[30:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/qslp_bisect_cell.sv =====
// One bisection step of the arccosine: evaluates cos(mid) and narrows the interval.
// Depends on qslp_pkg and qslp_sine.
`default_nettype none

module qslp_bisect_cell (
  input logic clk,
  input qslp_pkg::qs_item_t din,
  output qslp_pkg::qs_item_t dout
);
  import qslp_pkg::*;

  qs_item_t r0;
  qs_item_t r0_next;
  qs_item_t dout_next;
  qs_item_t dl [SIN_LAT];
  logic [30:0] arg;
  logic [30:0] cosv;
  logic [31:0] sum;

  assign sum = {1'b0, din.lo} + {1'b0, din.hi};

  always_comb begin
    r0_next = din;
    r0_next.mid = sum[31:1];
  end

  always_ff @(posedge clk) begin
    r0 <= r0_next;
    arg <= HALF_PI - sum[31:1];
  end

  qslp_sine u_sine (
    .clk(clk),
    .x(arg),
    .y(cosv)
  );

  always_ff @(posedge clk) begin
    dl[0] <= r0;
    for (int i = 1; i < SIN_LAT; i++) begin
      dl[i] <= dl[i-1];
    end
  end

  always_comb begin
    dout_next = dl[SIN_LAT-1];
    if ({2'b0, cosv} >= dl[SIN_LAT-1].dot) begin
      dout_next.lo = dl[SIN_LAT-1].mid;
    end else begin
      dout_next.hi = dl[SIN_LAT-1].mid;
    end
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
  end

endmodule

`default_nettype wire

// ===== rtl/core/qslp_div_cell.sv =====
// One restoring-division step for both slerp weights, one quotient bit each.
// Depends on qslp_pkg.
`default_nettype none

module qslp_div_cell (
  input logic clk,
  input qslp_pkg::qs_div_t din,
  output qslp_pkg::qs_div_t dout
);
  import qslp_pkg::*;

  logic [31:0] t0;
  logic [31:0] t1;
  logic [31:0] d0;
  logic [31:0] d1;
  logic ge0;
  logic ge1;
  qs_div_t dout_next;

  assign t0 = {din.rem0, din.num0[31]};
  assign t1 = {din.rem1, din.num1[31]};
  assign d0 = t0 - {1'b0, din.den};
  assign d1 = t1 - {1'b0, din.den};
  assign ge0 = t0 >= {1'b0, din.den};
  assign ge1 = t1 >= {1'b0, din.den};

  always_comb begin
    dout_next = din;
    dout_next.rem0 = ge0 ? d0[30:0] : t0[30:0];
    dout_next.rem1 = ge1 ? d1[30:0] : t1[30:0];
    dout_next.num0 = {din.num0[30:0], 1'b0};
    dout_next.num1 = {din.num1[30:0], 1'b0};
    dout_next.quo0 = {din.quo0[30:0], ge0};
    dout_next.quo1 = {din.quo1[30:0], ge1};
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
  end

endmodule

`default_nettype wire

// ===== rtl/core/quaternion_slerp_unit.sv =====
// done follows each start transfer down the valid shift register vpipe, alongside its data.
// Throughput: one item per cycle; busy is never asserted and results cannot be held off.
// The pipeline holds the 31 arccosine bisection cells of 19 stages each (one sine
// pipeline per cell), the weight sines and the 32-step weight divider.
// Reset clears the valid pipeline and sets the threshold thr to 1; no clearing pass.
// Top level of the quaternion slerp unit; depends on qslp_pkg and all qslp_ cells.
`default_nettype none

module quaternion_slerp_unit (
  input logic clk,
  input logic rst,
  input logic start,
  output logic busy,
  input logic cfg_valid,
  output logic cfg_ready,
  input logic [15:0] cfg_data,
  input qslp_pkg::qs_in_t operand,
  output logic done,
  output qslp_pkg::qs_out_t result
);
  import qslp_pkg::*;

  logic [TOTAL_LAT-1:0] vpipe;
  logic [15:0] thr;

  qs_in_t f0;
  qs_in_t f0_next;
  qs_in_t f1;
  qs_in_t f2;
  logic signed [15:0] a0 [4];
  logic signed [15:0] b0 [4];
  logic signed [15:0] a2 [4];
  logic signed [15:0] b2 [4];
  logic signed [31:0] prod [4];
  logic signed [33:0] dot2;
  logic [32:0] absd;
  logic neg;

  qs_item_t chain [NSTEP+1];

  logic [30:0] p1_w;
  logic [30:0] p1_a0;
  logic [30:0] p1_a1;
  qs_mix_t p1_mix;
  logic [47:0] ang0;
  logic [47:0] ang1;
  logic [30:0] sw;
  logic [30:0] g0;
  logic [30:0] g1;
  qs_mix_t mdl [SIN_LAT];

  qs_div_t dchain [QBITS+1];
  qs_div_t dhead_next;
  qs_div_t dend;
  logic [31:0] w0;
  logic [31:0] w1;
  logic signed [48:0] pa [4];
  logic signed [49:0] pb [4];
  logic signed [50:0] vsum [4];
  logic signed [15:0] sat [4];

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign done = vpipe[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
      thr <= 16'd1;
    end else begin
      vpipe <= {vpipe[TOTAL_LAT-2:0], start & ~busy};
      if (cfg_valid & cfg_ready) begin
        thr <= cfg_data;
      end
    end
  end

  assign a0[0] = f0.a_x;
  assign a0[1] = f0.a_y;
  assign a0[2] = f0.a_z;
  assign a0[3] = f0.a_w;
  assign b0[0] = f0.b_x;
  assign b0[1] = f0.b_y;
  assign b0[2] = f0.b_z;
  assign b0[3] = f0.b_w;
  assign a2[0] = f2.a_x;
  assign a2[1] = f2.a_y;
  assign a2[2] = f2.a_z;
  assign a2[3] = f2.a_w;
  assign b2[0] = f2.b_x;
  assign b2[1] = f2.b_y;
  assign b2[2] = f2.b_z;
  assign b2[3] = f2.b_w;

  assign neg = dot2[33];
  assign absd = neg ? 33'(-dot2) : dot2[32:0];

  always_comb begin
    f0_next = operand;
    if (operand.blend_t > 17'd65536) begin
      f0_next.blend_t = 17'd65536;
    end
  end

  always_ff @(posedge clk) begin
    f0 <= f0_next;
    f1 <= f0;
    for (int i = 0; i < 4; i++) begin
      prod[i] <= a0[i] * b0[i];
    end
    f2 <= f1;
    dot2 <= 34'(prod[0]) + 34'(prod[1]) + 34'(prod[2]) + 34'(prod[3]);
    for (int i = 0; i < 4; i++) begin
      chain[0].mix.a[i] <= a2[i];
      chain[0].mix.bn[i] <= neg ? -17'(b2[i]) : 17'(b2[i]);
    end
    chain[0].mix.t <= f2.blend_t;
    chain[0].mix.lin <= ({1'b0, absd[32:14]} + {4'b0, thr}) >= 20'h10000;
    chain[0].dot <= absd;
    chain[0].lo <= '0;
    chain[0].hi <= HALF_PI;
    chain[0].mid <= '0;
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_acos
    qslp_bisect_cell u_cell (
      .clk(clk),
      .din(chain[k]),
      .dout(chain[k+1])
    );
  end

  assign ang0 = chain[NSTEP].lo * (17'd65536 - chain[NSTEP].mix.t);
  assign ang1 = chain[NSTEP].lo * chain[NSTEP].mix.t;

  always_ff @(posedge clk) begin
    p1_w <= chain[NSTEP].lo;
    p1_a0 <= ang0[46:16];
    p1_a1 <= ang1[46:16];
    p1_mix <= chain[NSTEP].mix;
    mdl[0] <= p1_mix;
    for (int i = 1; i < SIN_LAT; i++) begin
      mdl[i] <= mdl[i-1];
    end
  end

  qslp_sine u_sin_w (
    .clk(clk),
    .x(p1_w),
    .y(sw)
  );

  qslp_sine u_sin_g0 (
    .clk(clk),
    .x(p1_a0),
    .y(g0)
  );

  qslp_sine u_sin_g1 (
    .clk(clk),
    .x(p1_a1),
    .y(g1)
  );

  always_comb begin
    dhead_next.mix = mdl[SIN_LAT-1];
    dhead_next.mix.lin = mdl[SIN_LAT-1].lin | (sw == 31'd0);
    dhead_next.den = sw;
    dhead_next.rem0 = {2'b0, g0[30:2]};
    dhead_next.rem1 = {2'b0, g1[30:2]};
    dhead_next.num0 = {g0[1:0], 30'b0};
    dhead_next.num1 = {g1[1:0], 30'b0};
    dhead_next.quo0 = '0;
    dhead_next.quo1 = '0;
  end

  always_ff @(posedge clk) begin
    dchain[0] <= dhead_next;
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_div
    qslp_div_cell u_cell (
      .clk(clk),
      .din(dchain[k]),
      .dout(dchain[k+1])
    );
  end

  assign dend = dchain[QBITS];
  assign w0 = dend.mix.lin ? {1'b0, 17'd65536 - dend.mix.t, 14'b0} : dend.quo0;
  assign w1 = dend.mix.lin ? {1'b0, dend.mix.t, 14'b0} : dend.quo1;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      pa[i] <= $signed({1'b0, w0}) * $signed(dend.mix.a[i]);
      pb[i] <= $signed({1'b0, w1}) * $signed(dend.mix.bn[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vsum[i] = 51'(pa[i]) + 51'(pb[i]) + 51'sd536870912;
      if ($signed(vsum[i][50:30]) > 21'sd32767) begin
        sat[i] = 16'sh7fff;
      end else if ($signed(vsum[i][50:30]) < -21'sd32768) begin
        sat[i] = -16'sh8000;
      end else begin
        sat[i] = vsum[i][45:30];
      end
    end
  end

  always_ff @(posedge clk) begin
    result.out_x <= sat[0];
    result.out_y <= sat[1];
    result.out_z <= sat[2];
    result.out_w <= sat[3];
  end

`include "quaternion_slerp_unit_assert.svh"

  `QSU_ASSERT_IMP(a_done_lat, done, $past(start, TOTAL_LAT), "done without matching start")
  `QSU_ASSERT_IMP(a_acos_conv, vpipe[ACOS_END-1], (chain[NSTEP].lo <= chain[NSTEP].hi) && ((chain[NSTEP].hi - chain[NSTEP].lo) <= 31'd1), "bisection did not converge")
  `QSU_ASSERT_IMP(a_div_pre, vpipe[ANG_END-1] && !dchain[0].mix.lin, (dchain[0].rem0 < dchain[0].den) && (dchain[0].rem1 < dchain[0].den), "weight quotient overflow")

endmodule

`default_nettype wire

// ===== tb/sv/quaternion_slerp_checker.sv =====
// Checker for the quaternion slerp unit: watches the operand, configuration and result
// transfers, predicts each result and compares it. Depends on qslp_pkg.
module quaternion_slerp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic [15:0] cfg_data,
  input qslp_pkg::qs_in_t operand,
  input logic done,
  input qslp_pkg::qs_out_t result,
  output int fail_count,
  output int pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import qslp_pkg::*;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned HPI_Q30 = 64'd1686629713;

  logic [15:0] threshold;
  qs_out_t slerp_q[$];

  function automatic longint unsigned sine_q30(longint unsigned x);
    longint unsigned x2, term;
    longint unsigned dv [5];
    dv = '{110, 72, 42, 20, 6};
    if (x > HPI_Q30) x = HPI_Q30;
    x2 = (x * x) >> 30;
    term = ONE_Q30;
    for (int i = 0; i < 5; i++) term = ONE_Q30 - ((x2 * term) >> 30) / dv[i];
    return (x * term) >> 30;
  endfunction

  function automatic longint unsigned arccos_q30(longint unsigned c);
    longint unsigned lo, hi, mid, m;
    lo = 0;
    hi = HPI_Q30;
    for (int i = 0; i < 31; i++) begin
      mid = (lo + hi) >> 1;
      m = (mid > HPI_Q30) ? HPI_Q30 : mid;
      if (sine_q30(HPI_Q30 - m) >= c) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic signed [15:0] round_q15(longint v);
    longint q;
    q = (v + (64'sd1 <<< 29)) >>> 30;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic qs_out_t slerp(qs_in_t op, logic [15:0] thr);
    longint av [4], bv [4];
    longint dot, d, s0, s1;
    longint unsigned t, w, sw, g0, g1;
    logic signed [15:0] r [4];
    qs_out_t o;
    av = '{op.a_x, op.a_y, op.a_z, op.a_w};
    bv = '{op.b_x, op.b_y, op.b_z, op.b_w};
    dot = 0;
    for (int i = 0; i < 4; i++) dot += av[i] * bv[i];
    t = op.blend_t > 17'd65536 ? 65536 : op.blend_t;
    if (dot < 0) begin
      dot = -dot;
      for (int i = 0; i < 4; i++) bv[i] = -bv[i];
    end
    d = 65536 - (dot >>> 14);
    s0 = longint'((65536 - t) << 14);
    s1 = longint'(t << 14);
    if (d > longint'(thr)) begin
      w = arccos_q30(dot);
      sw = sine_q30(w);
      if (sw != 0) begin
        g0 = sine_q30((w * (65536 - t)) >> 16);
        g1 = sine_q30((w * t) >> 16);
        s0 = longint'((g0 << 30) / sw);
        s1 = longint'((g1 << 30) / sw);
      end
    end
    for (int i = 0; i < 4; i++) r[i] = round_q15(s0 * av[i] + s1 * bv[i]);
    o.out_x = r[0];
    o.out_y = r[1];
    o.out_z = r[2];
    o.out_w = r[3];
    return o;
  endfunction

  assign pending = slerp_q.size();

  always @(posedge clk) begin
    qs_out_t e;
    if (rst) begin
      threshold <= 16'd1;
      fail_count <= 0;
      slerp_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) threshold <= cfg_data;
      if (start && !busy) slerp_q.push_back(slerp(operand, threshold));
      if (done) begin
        if (slerp_q.size() == 0) begin
          $error("result transfer with no expected result");
          fail_count <= fail_count + 1;
        end else begin
          e = slerp_q.pop_front();
          if (result !== e) begin
            if (result.out_x !== e.out_x) $error("out_x exp %0d got %0d", e.out_x, result.out_x);
            if (result.out_y !== e.out_y) $error("out_y exp %0d got %0d", e.out_y, result.out_y);
            if (result.out_z !== e.out_z) $error("out_z exp %0d got %0d", e.out_z, result.out_z);
            if (result.out_w !== e.out_w) $error("out_w exp %0d got %0d", e.out_w, result.out_w);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_quaternion_slerp_unit.sv =====
// Top of the quaternion slerp unit testbench: clock, reset, operand and register stimulus.
// Depends on qslp_pkg, quaternion_slerp_unit and quaternion_slerp_checker.
module tb_quaternion_slerp_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import qslp_pkg::*;

  logic clk = 0, rst = 1, start = 0, cfg_valid = 0;
  logic [15:0] cfg_data = '0;
  qs_in_t operand = '0;
  logic busy, cfg_ready, done;
  qs_out_t result;
  int fail_count, pending, sent;

  always #10 clk = ~clk;

  quaternion_slerp_unit dut (.*);
  quaternion_slerp_checker chk (.*);

  task automatic write_threshold(logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (TOTAL_LAT + 20) @(posedge clk);
  endtask

  function automatic logic [15:0] comp(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic qs_in_t rand_op();
    qs_in_t o;
    int k, s;
    o = $urandom();
    o.a_x = $urandom(); o.a_y = $urandom(); o.a_z = $urandom(); o.a_w = $urandom();
    k = $urandom_range(0, 9);
    if (k < 4) begin
      // Near-equal or opposite quaternions reach the fallback and small angles.
      s = $urandom_range(0, 1);
      o.b_x = (s ? -o.a_x : o.a_x) + $signed(16'($urandom_range(0, 64)) - 16'd32);
      o.b_y = (s ? -o.a_y : o.a_y) + $signed(16'($urandom_range(0, 64)) - 16'd32);
      o.b_z = (s ? -o.a_z : o.a_z) + $signed(16'($urandom_range(0, 64)) - 16'd32);
      o.b_w = (s ? -o.a_w : o.a_w) + $signed(16'($urandom_range(0, 64)) - 16'd32);
    end else begin
      o.b_x = $urandom(); o.b_y = $urandom(); o.b_z = $urandom(); o.b_w = $urandom();
    end
    case ($urandom_range(0, 5))
      0: o.blend_t = $urandom_range(65536, 131071);
      1: o.blend_t = $urandom_range(0, 1) ? 17'd0 : 17'd65536;
      default: o.blend_t = $urandom_range(0, 65536);
    endcase
    return o;
  endfunction

  task automatic send(qs_in_t o, bit idle_ok);
    while (idle_ok && $urandom_range(0, 99) < 21) begin
      @(posedge clk);
      start <= 0;
    end
    @(posedge clk);
    start <= 1;
    operand <= o;
    do @(posedge clk); while (busy);
    sent++;
    start <= 0;
  endtask

  task automatic send_burst(qs_in_t o, bit idle_ok);
    // Keeps start high across back-to-back items; with idle_ok set it may drop start between them at random.
    if (idle_ok && $urandom_range(0, 99) < 21) begin
      start <= 0;
      do @(posedge clk); while ($urandom_range(0, 99) < 21);
    end
    start <= 1;
    operand <= o;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  initial begin
    qs_in_t o;
    logic [15:0] thr [5];
    thr = '{16'd1, 16'd0, 16'hffff, 16'd300, 16'd20};
    sent = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int i = 0; i < 24; i++) begin
      o.a_x = comp(i % 4); o.a_y = comp((i / 4) % 4);
      o.a_z = comp(i % 3); o.a_w = comp((i + 1) % 4);
      o.b_x = comp((i + 2) % 4); o.b_y = comp(i % 4);
      o.b_z = comp((i / 2) % 4); o.b_w = comp((i + 3) % 4);
      o.blend_t = (i % 3 == 0) ? 17'd0 : (i % 3 == 1) ? 17'd65536 : 17'h1ffff;
      if (i == 20) o = '{16'h7fff, 0, 0, 0, 16'h7fff, 0, 0, 0, 17'd32768};
      if (i == 21) o = '{16'h7fff, 0, 0, 0, 16'h8000, 0, 0, 0, 17'd16384};
      if (i == 22) o = '{16'h7fff, 16'h7fff, 0, 0, 16'h7fff, 16'h7fff, 0, 0, 17'd100};
      if (i == 23) o = '{16'h5a82, 0, 0, 0, 0, 16'h5a82, 0, 0, 17'd40000};
      send(o, 1);
    end
    drain();
    for (int p = 0; p < 5; p++) begin
      write_threshold(p == 0 ? 16'd1 : thr[p]);
      for (int i = 0; i < 360; i++) send_burst(rand_op(), p != 2);
      start <= 0;
      drain();
    end
    $display("Sent %0d operand transfers across five threshold settings,", sent);
    $display("covering linear fallback, negated paths and saturated outputs.");
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
